[design/assert_macros.svh]
// Assertion macros shared by the touch mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication, checked on every clock edge outside reset.
`define ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

[design/tssm_pkg.sv]
// Shared types, constants and helpers of the touch sample to screen mapper.
package tssm_pkg;

	localparam int WORD_W   = 16;
	localparam int VAL_W    = 13;
	localparam int COORD_W  = 12;
	localparam int PROD_W   = VAL_W + COORD_W;
	localparam int STATUS_W = 3;
	localparam int CNT_W    = $clog2(COORD_W + 1);
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam int SCREEN_WIDTH_DEF  = 480;
	localparam int SCREEN_HEIGHT_DEF = 320;

	localparam logic [VAL_W:0]   PRESSURE_LIMIT   = 14'd4000;
	localparam logic [VAL_W-1:0] CAL_FIRST_RESET  = 13'd3600;
	localparam logic [VAL_W-1:0] CAL_SECOND_RESET = 13'd300;

	typedef enum logic [1:0] {
		REG_CAL_X_FIRST,
		REG_CAL_Y_FIRST,
		REG_CAL_X_SECOND,
		REG_CAL_Y_SECOND
	} reg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_SKIP,
		ST_BUSY,
		ST_WEAK,
		ST_RANGE,
		ST_TOUCH
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV_START,
		S_DIV_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [VAL_W-1:0] x_first;
		logic [VAL_W-1:0] y_first;
		logic [VAL_W-1:0] x_second;
		logic [VAL_W-1:0] y_second;
	} cal_t;

	typedef struct packed {
		logic               done;
		logic               overflow;
		logic [COORD_W-1:0] quotient;
	} div_stat_t;

	// The ADC value sits in the upper 13 bits of the response word.
	function automatic logic [VAL_W-1:0] word_value(input logic [WORD_W-1:0] w);
		return w[WORD_W-1:WORD_W-VAL_W];
	endfunction

endpackage

[design/tssm_in_if.sv]
// Input channel of the touch mapper: one touch interrupt per beat.
interface tssm_in_if;
	logic                          valid;
	logic                          ready;
	logic                          display_busy;
	logic [tssm_pkg::WORD_W-1:0]   x_word_a;
	logic [tssm_pkg::WORD_W-1:0]   x_word_b;
	logic [tssm_pkg::WORD_W-1:0]   x_word_c;
	logic [tssm_pkg::WORD_W-1:0]   x_word_d;
	logic [tssm_pkg::WORD_W-1:0]   y_word_a;
	logic [tssm_pkg::WORD_W-1:0]   y_word_b;
	logic [tssm_pkg::WORD_W-1:0]   y_word_c;
	logic [tssm_pkg::WORD_W-1:0]   y_word_d;
	logic [tssm_pkg::WORD_W-1:0]   pressure_one_word;
	logic [tssm_pkg::WORD_W-1:0]   pressure_two_word;

	modport source (
		output valid, display_busy, x_word_a, x_word_b, x_word_c, x_word_d,
		output y_word_a, y_word_b, y_word_c, y_word_d,
		output pressure_one_word, pressure_two_word,
		input  ready
	);

	modport sink (
		input  valid, display_busy, x_word_a, x_word_b, x_word_c, x_word_d,
		input  y_word_a, y_word_b, y_word_c, y_word_d,
		input  pressure_one_word, pressure_two_word,
		output ready
	);
endinterface

[design/tssm_out_if.sv]
// Output channel of the touch mapper: one status and position per beat.
interface tssm_out_if;
	logic                            valid;
	logic                            ready;
	logic [tssm_pkg::STATUS_W-1:0]   status;
	logic [tssm_pkg::COORD_W-1:0]    screen_x;
	logic [tssm_pkg::COORD_W-1:0]    screen_y;

	modport source (
		output valid, status, screen_x, screen_y,
		input  ready
	);

	modport sink (
		input  valid, status, screen_x, screen_y,
		output ready
	);
endinterface

[design/tssm_apb_regs.sv]
// APB register file holding the four calibration corner values.
module tssm_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tssm_pkg::ADDR_W-1:0]   paddr,
	input  logic [tssm_pkg::DATA_W-1:0]   pwdata,
	output logic [tssm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output tssm_pkg::cal_t                cal
);

	tssm_pkg::cal_t     cal_q;
	tssm_pkg::reg_idx_t idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = tssm_pkg::reg_idx_t'(paddr[tssm_pkg::ADDR_W-1:2]);
	assign cal    = cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q.x_first  <= tssm_pkg::CAL_FIRST_RESET;
			cal_q.y_first  <= tssm_pkg::CAL_FIRST_RESET;
			cal_q.x_second <= tssm_pkg::CAL_SECOND_RESET;
			cal_q.y_second <= tssm_pkg::CAL_SECOND_RESET;
		end else if (wr_en) begin
			case (idx)
				tssm_pkg::REG_CAL_X_FIRST:  cal_q.x_first  <= pwdata[tssm_pkg::VAL_W-1:0];
				tssm_pkg::REG_CAL_Y_FIRST:  cal_q.y_first  <= pwdata[tssm_pkg::VAL_W-1:0];
				tssm_pkg::REG_CAL_X_SECOND: cal_q.x_second <= pwdata[tssm_pkg::VAL_W-1:0];
				tssm_pkg::REG_CAL_Y_SECOND: cal_q.y_second <= pwdata[tssm_pkg::VAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			tssm_pkg::REG_CAL_X_FIRST:  prdata = tssm_pkg::DATA_W'(cal_q.x_first);
			tssm_pkg::REG_CAL_Y_FIRST:  prdata = tssm_pkg::DATA_W'(cal_q.y_first);
			tssm_pkg::REG_CAL_X_SECOND: prdata = tssm_pkg::DATA_W'(cal_q.x_second);
			tssm_pkg::REG_CAL_Y_SECOND: prdata = tssm_pkg::DATA_W'(cal_q.y_second);
			default:                    prdata = '0;
		endcase
	end

endmodule

[design/tssm_divider.sv]
// Restoring divider, one quotient bit per cycle, with an early overflow test.
module tssm_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tssm_pkg::PROD_W-1:0]   dividend,
	input  logic [tssm_pkg::VAL_W-1:0]    divisor,
	output tssm_pkg::div_stat_t           stat
);

	localparam int VW = tssm_pkg::VAL_W;
	localparam int CW = tssm_pkg::COORD_W;
	localparam int PW = tssm_pkg::PROD_W;

	logic                      run_q;
	logic                      done_q;
	logic                      ovf_q;
	logic [tssm_pkg::CNT_W-1:0] cnt_q;
	logic [VW-1:0]             rem_q;
	logic [VW-1:0]             div_q;
	logic [CW-1:0]             quo_q;

	logic                      ovf_now;
	logic [VW:0]               partial;
	logic [VW:0]               diff;
	logic                      take;

	// A quotient that needs more than CW bits is reported at once.
	assign ovf_now = dividend[PW-1:CW] >= divisor;
	assign partial = {rem_q, quo_q[CW-1]};
	assign take    = partial >= {1'b0, div_q};
	assign diff    = partial - {1'b0, div_q};

	assign stat.done     = done_q;
	assign stat.overflow = ovf_q;
	assign stat.quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				ovf_q  <= ovf_now;
				run_q  <= !ovf_now;
				done_q <= ovf_now;
				cnt_q  <= tssm_pkg::CNT_W'(CW);
			end else begin
				done_q <= run_q && (cnt_q == tssm_pkg::CNT_W'(1));
				if (run_q) begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == tssm_pkg::CNT_W'(1))
						run_q <= 1'b0;
				end
			end
		end
	end

	// The low dividend bits shift out of quo_q while quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[PW-1:CW];
			quo_q <= dividend[CW-1:0];
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= take ? diff[VW-1:0] : partial[VW-1:0];
			quo_q <= {quo_q[CW-2:0], take};
		end
	end

endmodule

[design/touch_sample_to_screen_mapper.sv]
// Touch sample to screen mapper top level: sequencer, shared multiplier and divider.
//
// Usage:
// The sample channel takes one touch interrupt per beat: a busy flag, four X
// words, four Y words and two pressure words. The result channel returns one
// beat per sample: a status code and, for a valid touch, the screen column
// and row. Calibration corners are to be written over the APB port only while
// idle; the block itself does not enforce this. Every second interrupt is
// swallowed, busy interrupts are dropped, and weak presses are rejected; these
// go from the idle state straight to the done state. A touch that is mapped
// uses one multiplier and one bit-serial divider for each axis in turn: the
// multiply state, the divider start state and the divider wait state, which
// lasts while the 12-step divider runs.
// A sample is accepted only while the sequencer is idle; ready rises at the
// edge that loads the previous result into the output register.
// When the receiver stalls, the finished result waits in the output register
// and the next sample may still be taken and computed; it then waits to load.
// Reset clears the toggle, restores the default corners and empties the output.
`include "assert_macros.svh"

module touch_sample_to_screen_mapper #(
	parameter int SCREEN_WIDTH  = tssm_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = tssm_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tssm_pkg::ADDR_W-1:0]   paddr,
	input  logic [tssm_pkg::DATA_W-1:0]   pwdata,
	output logic [tssm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	tssm_in_if.sink                       sample,
	tssm_out_if.source                    result
);

	localparam int VW = tssm_pkg::VAL_W;
	localparam int CW = tssm_pkg::COORD_W;
	localparam int PW = tssm_pkg::PROD_W;
	localparam logic [CW-1:0] SIZE_X = CW'(SCREEN_WIDTH);
	localparam logic [CW-1:0] SIZE_Y = CW'(SCREEN_HEIGHT);

	tssm_pkg::cal_t      cal;
	tssm_pkg::div_stat_t div_stat;
	tssm_pkg::state_t    state_q, state_d;
	tssm_pkg::status_t   status_q, out_status_q;

	logic          skip_q;
	logic          axis_q;
	logic          out_valid_q;
	logic [VW-1:0] avg_x_q, avg_y_q;
	logic [PW-1:0] prod_q;
	logic [VW-1:0] hi_q;
	logic          mirror_q;
	logic [CW-1:0] sx_q, sy_q;
	logic [CW-1:0] out_x_q, out_y_q;

	logic          accept;
	logic          load;
	logic          div_start;
	logic          weak_press;
	logic [VW+1:0] sum_x, sum_y;
	logic [VW-1:0] avg_cur, first_cur, second_cur, lo, hi;
	logic          mirror;
	logic          axis_bad;
	logic [CW-1:0] size_cur;
	logic [PW-1:0] prod;
	logic          q_bad;
	logic [CW-1:0] coord;

	tssm_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cal     (cal)
	);

	tssm_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (hi_q),
		.stat     (div_stat)
	);

	assign sample.ready = (state_q == tssm_pkg::S_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign load         = (state_q == tssm_pkg::S_DONE) && (!out_valid_q || result.ready);

	assign result.valid    = out_valid_q;
	assign result.status   = out_status_q;
	assign result.screen_x = out_x_q;
	assign result.screen_y = out_y_q;

	// A z2 minus z1 of the limit or more is a weak press; a negative one passes.
	assign weak_press = {1'b0, tssm_pkg::word_value(sample.pressure_two_word)} >=
		({1'b0, tssm_pkg::word_value(sample.pressure_one_word)} + tssm_pkg::PRESSURE_LIMIT);

	assign sum_x = (VW+2)'(tssm_pkg::word_value(sample.x_word_a))
		+ (VW+2)'(tssm_pkg::word_value(sample.x_word_b))
		+ (VW+2)'(tssm_pkg::word_value(sample.x_word_c))
		+ (VW+2)'(tssm_pkg::word_value(sample.x_word_d));
	assign sum_y = (VW+2)'(tssm_pkg::word_value(sample.y_word_a))
		+ (VW+2)'(tssm_pkg::word_value(sample.y_word_b))
		+ (VW+2)'(tssm_pkg::word_value(sample.y_word_c))
		+ (VW+2)'(tssm_pkg::word_value(sample.y_word_d));

	// Per-axis operand selection for the shared multiplier and divider.
	assign avg_cur    = axis_q ? avg_y_q : avg_x_q;
	assign first_cur  = axis_q ? cal.y_first : cal.x_first;
	assign second_cur = axis_q ? cal.y_second : cal.x_second;
	assign size_cur   = axis_q ? SIZE_Y : SIZE_X;
	assign mirror     = first_cur > second_cur;
	assign lo         = mirror ? second_cur : first_cur;
	assign hi         = mirror ? first_cur : second_cur;
	assign axis_bad   = (hi == '0) || (avg_cur < lo);
	assign prod       = PW'(avg_cur - lo) * PW'(size_cur);

	assign q_bad = div_stat.overflow || (div_stat.quotient > size_cur);
	assign coord = mirror_q ? (size_cur - div_stat.quotient) : div_stat.quotient;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tssm_pkg::S_IDLE;
			skip_q      <= 1'b0;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				skip_q <= !skip_q && !sample.display_busy;
				axis_q <= 1'b0;
			end
			if (state_q == tssm_pkg::S_DIV_WAIT && div_stat.done && !q_bad)
				axis_q <= 1'b1;
			if (load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		case (state_q)
			tssm_pkg::S_IDLE: begin
				if (sample.valid)
					state_d = (skip_q || sample.display_busy || weak_press) ?
						tssm_pkg::S_DONE : tssm_pkg::S_MUL;
			end
			tssm_pkg::S_MUL: begin
				state_d = axis_bad ? tssm_pkg::S_DONE : tssm_pkg::S_DIV_START;
			end
			tssm_pkg::S_DIV_START: begin
				div_start = 1'b1;
				state_d   = tssm_pkg::S_DIV_WAIT;
			end
			tssm_pkg::S_DIV_WAIT: begin
				if (div_stat.done)
					state_d = (q_bad || axis_q) ? tssm_pkg::S_DONE : tssm_pkg::S_MUL;
			end
			tssm_pkg::S_DONE: begin
				if (!out_valid_q || result.ready)
					state_d = tssm_pkg::S_IDLE;
			end
			default: state_d = tssm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tssm_pkg::S_IDLE: begin
				if (sample.valid) begin
					avg_x_q <= sum_x[VW+1:2];
					avg_y_q <= sum_y[VW+1:2];
					if (skip_q)
						status_q <= tssm_pkg::ST_SKIP;
					else if (sample.display_busy)
						status_q <= tssm_pkg::ST_BUSY;
					else if (weak_press)
						status_q <= tssm_pkg::ST_WEAK;
				end
			end
			tssm_pkg::S_MUL: begin
				prod_q   <= prod;
				hi_q     <= hi;
				mirror_q <= mirror;
				if (axis_bad)
					status_q <= tssm_pkg::ST_RANGE;
			end
			tssm_pkg::S_DIV_WAIT: begin
				if (div_stat.done) begin
					if (q_bad) begin
						status_q <= tssm_pkg::ST_RANGE;
					end else if (axis_q) begin
						sy_q     <= coord;
						status_q <= tssm_pkg::ST_TOUCH;
					end else begin
						sx_q <= coord;
					end
				end
			end
			tssm_pkg::S_DONE: begin
				if (load) begin
					out_status_q <= status_q;
					out_x_q      <= (status_q == tssm_pkg::ST_TOUCH) ? sx_q : '0;
					out_y_q      <= (status_q == tssm_pkg::ST_TOUCH) ? sy_q : '0;
				end
			end
			default: ;
		endcase
	end

	`ASSERT_IMP(a_touch_on_screen, result.valid && result.status == tssm_pkg::ST_TOUCH, result.screen_x <= SIZE_X && result.screen_y <= SIZE_Y)
	`ASSERT_IMP(a_reject_zero_coords, result.valid && result.status != tssm_pkg::ST_TOUCH, result.screen_x == '0 && result.screen_y == '0)
	`ASSERT_NXT(a_skip_clears, accept && skip_q, !skip_q)
	`ASSERT_IMP(a_div_done_in_wait, div_stat.done, state_q == tssm_pkg::S_DIV_WAIT)

endmodule
